[rtl/tlbpt_pkg.sv]
`timescale 1ns / 1ps

package tlbpt_pkg;

  localparam int TLB_ENTRIES = 16;
  localparam int PAGE_COUNT  = 256;
  localparam int PAGE_BYTES  = 256;

  localparam int ADDR_W     = 16;
  localparam int PAGE_W     = 8;
  localparam int FRAME_W    = 8;
  localparam int ALLOC_W    = 9;
  localparam int COUNT_W    = 32;
  localparam int MAP_IDX_W  = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int TLB_FILL_W = $clog2(TLB_ENTRIES + 1);

  localparam logic [ADDR_W-1:0] PAGE_MASK   = 16'hFF00;
  localparam logic [ADDR_W-1:0] OFFSET_MASK = 16'h00FF;

  typedef logic [PAGE_W-1:0]    page_t;
  typedef logic [FRAME_W-1:0]   frame_t;
  typedef logic [MAP_IDX_W-1:0] map_idx_t;

  // Page table access from the translation control.
  typedef struct packed {
    logic     rd_en;
    map_idx_t rd_idx;
    logic     wr_en;
    map_idx_t wr_idx;
    frame_t   wr_frame;
  } map_req_t;

endpackage

[rtl/tlbpt_map.sv]
`timescale 1ns / 1ps

module tlbpt_map import tlbpt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  map_req_t req,
  output logic     rd_valid,
  output frame_t   rd_frame
);

  frame_t                mem [PAGE_COUNT];
  logic [PAGE_COUNT-1:0] valid_bits;

  // Valid bits: cleared at reset, read registered alongside the frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
      rd_valid   <= 1'b0;
    end else begin
      if (req.rd_en) begin
        rd_valid <= valid_bits[req.rd_idx];
      end
      if (req.wr_en) begin
        valid_bits[req.wr_idx] <= 1'b1;
      end
    end
  end

  // Frame storage: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_idx] <= req.wr_frame;
    end
    if (req.rd_en) begin
      rd_frame <= mem[req.rd_idx];
    end
  end

endmodule

[rtl/tlb_page_table_translator_core.sv]
`timescale 1ns / 1ps
// Flow: the input transfer latches the address and starts the registered page table read;
//   the resolve step then loads the result register, waiting while an old result is undrained.
// A new address is accepted only once the resolve step of the previous one, which may write
//   the page table and TLB, has completed.
// Reset (rst, synchronous): empties the TLB, clears all page table valid bits,
//   and zeroes the frame allocator and both counters.

module tlb_page_table_translator_core import tlbpt_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [ADDR_W-1:0]   vaddr,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [ADDR_W-1:0]   paddr,
  output logic                tlb_hit,
  output logic                page_fault,
  output logic [COUNT_W-1:0]  hit_total,
  output logic [COUNT_W-1:0]  fault_total
);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_LOOKUP = 1'b1;

  logic state;

  // Latched address of the item in flight.
  logic [ADDR_W-1:0] addr;

  // TLB: a shift line, newest at entry zero.
  page_t                 tlb_page_tag  [TLB_ENTRIES];
  frame_t                tlb_frame_num [TLB_ENTRIES];
  logic [TLB_FILL_W-1:0] tlb_fill;

  logic [ALLOC_W-1:0] next_free_frame;
  logic [COUNT_W-1:0] hit_counter;
  logic [COUNT_W-1:0] fault_counter;

  map_req_t map_req;
  logic     map_rd_valid;
  frame_t   map_rd_frame;

  page_t                 cur_page;
  logic [PAGE_W-1:0]     cur_offset;
  map_idx_t              cur_idx;
  map_idx_t              in_idx;
  logic                  tlb_match;
  frame_t                tlb_frame;
  logic                  fault;
  frame_t                frame_sel;
  logic [31:0]           phys_full;
  logic                  finish;
  logic                  in_xfer;
  logic [TLB_FILL_W-1:0] tlb_fill_next;

  assign in_ready = (state == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;

  // Complete the lookup once the output register is free or being drained.
  assign finish = (state == ST_LOOKUP) && (!out_valid || out_ready);

  assign cur_page   = page_t'((addr & PAGE_MASK) >> 8);
  assign cur_offset = addr[PAGE_W-1:0];
  assign cur_idx    = map_idx_t'(cur_page % PAGE_COUNT);
  assign in_idx     = map_idx_t'(page_t'((vaddr & PAGE_MASK) >> 8) % PAGE_COUNT);

  // Parallel tag compare; on duplicate tags the oldest (highest) entry wins.
  always_comb begin
    tlb_match = 1'b0;
    tlb_frame = '0;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      if ((TLB_FILL_W'(i) < tlb_fill) && (tlb_page_tag[i] == cur_page)) begin
        tlb_match = 1'b1;
        tlb_frame = tlb_frame_num[i];
      end
    end
  end

  assign fault = !tlb_match && !map_rd_valid;

  always_comb begin
    if (tlb_match) begin
      frame_sel = tlb_frame;
    end else if (fault) begin
      frame_sel = next_free_frame[FRAME_W-1:0];
    end else begin
      frame_sel = map_rd_frame;
    end
  end

  assign phys_full = {{(32-FRAME_W){1'b0}}, frame_sel} * PAGE_BYTES
                   + {{(32-PAGE_W){1'b0}}, cur_offset};

  assign tlb_fill_next = (tlb_fill >= TLB_FILL_W'(TLB_ENTRIES)) ?
                         TLB_FILL_W'(TLB_ENTRIES) : tlb_fill + TLB_FILL_W'(1);

  // Read the page table on input transfer; write back a new mapping on a fault.
  always_comb begin
    map_req.rd_en    = in_xfer;
    map_req.rd_idx   = in_idx;
    map_req.wr_en    = finish && fault;
    map_req.wr_idx   = cur_idx;
    map_req.wr_frame = next_free_frame[FRAME_W-1:0];
  end

  tlbpt_map u_map (
    .clk      (clk),
    .rst      (rst),
    .req      (map_req),
    .rd_valid (map_rd_valid),
    .rd_frame (map_rd_frame)
  );

  // Control: state, fill, allocator, counters, output handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      tlb_fill        <= '0;
      next_free_frame <= '0;
      hit_counter     <= '0;
      fault_counter   <= '0;
      out_valid       <= 1'b0;
    end else begin
      // Drop valid on a result transfer unless a new result replaces it.
      if (out_valid && out_ready && !finish) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            state <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          if (finish) begin
            state     <= ST_IDLE;
            out_valid <= 1'b1;
            if (tlb_match) begin
              if (hit_counter != '1) begin
                hit_counter <= hit_counter + 1'b1;
              end
            end else if (fault) begin
              next_free_frame <= next_free_frame + 1'b1;
              tlb_fill        <= tlb_fill_next;
              if (fault_counter != '1) begin
                fault_counter <= fault_counter + 1'b1;
              end
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload: latched address, TLB shift on fault, result register.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      addr <= vaddr;
    end
    if (finish) begin
      paddr            <= phys_full[ADDR_W-1:0];
      tlb_hit          <= tlb_match;
      page_fault       <= fault;
      hit_total        <= (tlb_match && hit_counter != '1) ? hit_counter + 1'b1
                                                          : hit_counter;
      fault_total      <= (fault && fault_counter != '1) ? fault_counter + 1'b1
                                                        : fault_counter;
      if (fault) begin
        // Push the new mapping at the front; the oldest entry drops off the end.
        for (int i = TLB_ENTRIES - 1; i > 0; i--) begin
          tlb_page_tag[i]  <= tlb_page_tag[i-1];
          tlb_frame_num[i] <= tlb_frame_num[i-1];
        end
        tlb_page_tag[0]  <= cur_page;
        tlb_frame_num[0] <= next_free_frame[FRAME_W-1:0];
      end
    end
  end

endmodule
